FILE: hw/rtl/rws_pkg.sv
package rws_pkg;

    localparam int DEF_MAX_ENTRIES  = 64;
    localparam int DEF_FITNESS_BITS = 32;
    localparam int DEF_RANDOM_BITS  = 32;

    localparam int MUL_DIGIT_BITS = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic cmp_en;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/rws_cell.sv
module rws_cell #(
    parameter int SUM_W    = 38,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rws_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [SUM_W-1:0]   wr_data,
    input  logic [CNT_W-1:0]   count,
    input  logic [SUM_W-1:0]   target,
    input  logic               le_next,
    output logic               le,
    output logic               hit
);
    import rws_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    logic             le_reg;
    logic             le_next_val;
    logic             in_set;

    assign in_set      = CNT_W'(CELL_IDX) < count;
    assign le_next_val = in_set && (sum_reg <= target);

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && (wr_idx == IDX_W'(CELL_IDX)))
        begin
            sum_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            le_reg <= le_next_val;
        end
    end

    // boundary of the thermometer: last entry at or below the target
    assign le  = le_reg;
    assign hit = le_reg && !le_next;

endmodule

FILE: hw/rtl/rws_mul.sv
module rws_mul #(
    parameter int A_W = 32,
    parameter int B_W = 38
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 done,
    output logic [A_W+B_W-1:0]   product
);
    import rws_pkg::*;

    localparam int D   = MUL_DIGIT_BITS;
    localparam int ND  = (B_W + D - 1) / D;
    localparam int OPW = ND * D;
    localparam int PW  = A_W + OPW;
    localparam int KW  = (ND > 1) ? $clog2(ND) : 1;

    logic [A_W-1:0]   a_reg;
    logic [OPW-1:0]   b_reg;
    logic [KW-1:0]    k_reg;
    logic             run_reg;
    logic             pp_valid_reg;
    logic             pp_last_reg;
    logic             done_reg;
    logic [PW-1:0]    pp_reg;
    logic [PW-1:0]    acc_reg;
    logic [D-1:0]     digit;
    logic [A_W+D-1:0] mul;
    logic             last_step;

    assign digit     = b_reg[k_reg*D +: D];
    assign mul       = (A_W+D)'(a_reg) * (A_W+D)'(digit);
    assign last_step = (k_reg == KW'(ND - 1));

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= OPW'(b);
        end
        if (run_reg)
        begin
            pp_reg <= PW'(mul) << (D * int'(k_reg));
        end
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (pp_valid_reg)
        begin
            acc_reg <= acc_reg + pp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            k_reg        <= '0;
            pp_valid_reg <= 1'b0;
            pp_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pp_valid_reg <= run_reg;
            pp_last_reg  <= run_reg && last_step;
            done_reg     <= pp_valid_reg && pp_last_reg;
            if (start)
            begin
                run_reg <= 1'b1;
                k_reg   <= '0;
            end
            else if (run_reg)
            begin
                if (last_step)
                begin
                    run_reg <= 1'b0;
                end
                k_reg <= k_reg + KW'(1);
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[A_W+B_W-1:0];

endmodule

FILE: hw/rtl/roulette_wheel_selector.sv
// channel  | handshake           | payload
// ---------+---------------------+---------------------------------------------
// input    | start, busy         | operation, restart, fitness, random_fraction
// result   | done (1-cycle pulse)| selected_index, uniform_fallback
//
// A load yields no result. A draw raises busy; its product is formed by the
// 16-bit-digit multiplier and then, unless the total is zero, passes the row of
// compare cells (ST_CMP) and the encoder (ST_ENC) before the result is registered.
// When the total is zero, the result comes from the multiplier alone. A draw on an
// empty table yields nothing. Reset clears the count and total; stored sums need no
// clearing. Results cannot be held off.
module roulette_wheel_selector #(
    parameter int MAX_ENTRIES  = rws_pkg::DEF_MAX_ENTRIES,
    parameter int FITNESS_BITS = rws_pkg::DEF_FITNESS_BITS,
    parameter int RANDOM_BITS  = rws_pkg::DEF_RANDOM_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic                           restart,
    input  logic [FITNESS_BITS-1:0]        fitness,
    input  logic [RANDOM_BITS-1:0]         random_fraction,
    output logic                           done,
    output logic [$clog2(MAX_ENTRIES)-1:0] selected_index,
    output logic                           uniform_fallback
);
    import rws_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = FITNESS_BITS + IDX_W;
    localparam int PRD_W = RANDOM_BITS + SUM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_ENC  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic             fallback_reg, fallback_next;
    logic             done_reg, done_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic             uniform_reg, uniform_next;

    logic             accept;
    logic             load;
    logic             draw;
    logic [CNT_W-1:0] base_cnt;
    logic [SUM_W-1:0] base_tot;
    logic [SUM_W-1:0] new_tot;
    logic             table_open;
    cell_ctl_t        ctl;
    logic [IDX_W-1:0] wr_idx;
    logic [SUM_W-1:0] mul_opr;
    logic             mul_done;
    logic [PRD_W-1:0] product;
    logic [SUM_W-1:0] target;
    logic [CNT_W-1:0] pick;
    logic [IDX_W-1:0] pick_idx;
    logic [IDX_W:0]   enc;
    logic [MAX_ENTRIES-1:0] le_row;
    logic [MAX_ENTRIES-1:0] hit_row;

    assign accept = start && !busy;
    assign load   = accept && (operation == OP_LOAD);
    assign draw   = accept && (operation == OP_DRAW) && (count_reg != '0);

    assign base_cnt   = restart ? '0 : count_reg;
    assign base_tot   = restart ? '0 : total_reg;
    assign new_tot    = base_tot + SUM_W'(fitness);
    assign table_open = base_cnt < CNT_W'(MAX_ENTRIES);
    assign wr_idx     = base_cnt[IDX_W-1:0];

    assign mul_opr = (total_reg == '0) ? SUM_W'(count_reg) : total_reg;

    rws_mul #(
        .A_W (RANDOM_BITS),
        .B_W (SUM_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (draw),
        .a       (random_fraction),
        .b       (mul_opr),
        .done    (mul_done),
        .product (product)
    );

    assign target = product[RANDOM_BITS +: SUM_W];
    assign pick   = (product[RANDOM_BITS +: CNT_W] >= count_reg)
                  ? count_reg - CNT_W'(1) : product[RANDOM_BITS +: CNT_W];
    assign pick_idx = pick[IDX_W-1:0];

    assign ctl.wr_en  = load && table_open;
    assign ctl.cmp_en = (state_reg == ST_CMP);

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic le_nb;
        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign le_nb = 1'b0;
        end
        else
        begin : g_link
            assign le_nb = le_row[i+1];
        end

        rws_cell #(
            .SUM_W    (SUM_W),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .wr_idx  (wr_idx),
            .wr_data (new_tot),
            .count   (count_reg),
            .target  (target),
            .le_next (le_nb),
            .le      (le_row[i]),
            .hit     (hit_row[i])
        );
    end

    always_comb
    begin
        enc = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (hit_row[i])
            begin
                enc = enc | (IDX_W+1)'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        fallback_next = fallback_reg;
        done_next     = 1'b0;
        index_next    = index_reg;
        uniform_next  = uniform_reg;

        if (load)
        begin
            count_next = base_cnt;
            total_next = base_tot;
            if (table_open)
            begin
                count_next = base_cnt + CNT_W'(1);
                total_next = new_tot;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (draw)
                begin
                    fallback_next = (total_reg == '0);
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (fallback_reg)
                    begin
                        done_next    = 1'b1;
                        index_next   = pick_idx;
                        uniform_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                state_next = ST_ENC;
            end
            ST_ENC:
            begin
                done_next    = 1'b1;
                index_next   = enc[IDX_W-1:0];
                uniform_next = 1'b0;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            fallback_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            fallback_reg <= fallback_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg   <= index_next;
        uniform_reg <= uniform_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign selected_index   = index_reg;
    assign uniform_fallback = uniform_reg;

endmodule
